### rtl/sdiv_pkg.sv
// shared constants and types for the divide instruction executor
`timescale 1ns / 1ps
`default_nettype none

package sdiv_pkg;

  localparam int DATA_W     = 32;
  localparam int REG_COUNT  = 16;
  localparam int REG_ADDR_W = 4;
  localparam int APB_ADDR_W = 3;
  localparam int S_TDATA_W  = 72;
  localparam int S_TUSER_W  = 3;
  localparam int M_TDATA_W  = 72;
  localparam int M_TUSER_W  = 2;

  localparam logic [REG_ADDR_W-1:0] PC_INDEX = 4'd15;
  localparam logic [DATA_W-1:0]     PC_STEP  = 32'd4;

  // commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_EXEC  = 2'd2;

  // result status
  localparam logic [1:0] STATUS_DONE   = 2'd0;
  localparam logic [1:0] STATUS_TRAP   = 2'd1;
  localparam logic [1:0] STATUS_NOTDIV = 2'd2;

  // configuration register index
  localparam logic REG_ZERO_DIVIDE_TRAP = 1'b0;

  // instruction encodings
  localparam logic [31:0] ARM_MASK     = 32'h0ff0f0f0;
  localparam logic [31:0] ARM_SDIV     = 32'h0710f010;
  localparam logic [31:0] ARM_UDIV     = 32'h0730f010;
  localparam logic [31:0] THUMB_MASK   = 32'hfff0f0f0;
  localparam logic [31:0] THUMB_SDIV   = 32'hfb90f0f0;
  localparam logic [31:0] THUMB_UDIV   = 32'hfbb0f0f0;

  typedef struct packed {
    logic                  is_div;
    logic                  is_signed;
    logic [REG_ADDR_W-1:0] rn;
    logic [REG_ADDR_W-1:0] rm;
    logic [REG_ADDR_W-1:0] rd;
  } decode_t;

  function automatic decode_t decode_instr(input logic [31:0] w, input logic thumb);
    decode_t d;
    d = '0;
    if (thumb) begin
      d.is_div    = ((w & THUMB_MASK) == THUMB_SDIV) || ((w & THUMB_MASK) == THUMB_UDIV);
      d.is_signed = (w & THUMB_MASK) == THUMB_SDIV;
      d.rn        = w[19:16];
      d.rm        = w[3:0];
      d.rd        = w[11:8];
    end else begin
      d.is_div    = ((w & ARM_MASK) == ARM_SDIV) || ((w & ARM_MASK) == ARM_UDIV);
      d.is_signed = (w & ARM_MASK) == ARM_SDIV;
      d.rn        = w[3:0];
      d.rm        = w[11:8];
      d.rd        = w[19:16];
    end
    return d;
  endfunction

endpackage

`default_nettype wire

### rtl/sdiv_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module sdiv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/sdiv_divider.sv
// radix-2 restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module sdiv_divider (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [sdiv_pkg::DATA_W-1:0] dividend,
  input  wire logic [sdiv_pkg::DATA_W-1:0] divisor,
  output logic                            done,
  output logic      [sdiv_pkg::DATA_W-1:0] quo
);

  localparam int CNT_W = $clog2(sdiv_pkg::DATA_W);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [sdiv_pkg::DATA_W-1:0]   rem;
  logic [sdiv_pkg::DATA_W-1:0]   dvs;
  logic [sdiv_pkg::DATA_W:0]     trial;
  logic [sdiv_pkg::DATA_W:0]     diff;

  assign trial = {rem, quo[sdiv_pkg::DATA_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(sdiv_pkg::DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[sdiv_pkg::DATA_W]) begin
        rem <= diff[sdiv_pkg::DATA_W-1:0];
        quo <= {quo[sdiv_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem <= trial[sdiv_pkg::DATA_W-1:0];
        quo <= {quo[sdiv_pkg::DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

### rtl/sdiv_udiv_instruction_executor.sv
// Executor for SDIV/UDIV instruction words over a 16 x 32-bit register file
// (r15 is the program counter). One command is taken at a time; s_tready is
// high only while the sequencer is idle. A register write and a non-divide
// word go from dispatch straight to the result state, a read passes through
// a read state first, and an executed divide runs operand reads through the
// single read port of the register file, the radix-2 divider, then the
// quotient write and a read-modify-write of the program counter. A zero
// divisor skips the divider. A finished result waits in the output register
// until taken, and the next command can be accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module sdiv_udiv_instruction_executor (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // stream in
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // reg_index[3:0], write_value[35:4], instruction[67:36], zero pad
  input  wire logic [sdiv_pkg::S_TDATA_W-1:0]    s_tdata,
  // command[1:0], thumb_mode[2]
  input  wire logic [sdiv_pkg::S_TUSER_W-1:0]    s_tuser,
  // stream out
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // read_value[31:0], dest_index[35:32], quotient[67:36], zero pad
  output logic      [sdiv_pkg::M_TDATA_W-1:0]    m_tdata,
  // status[1:0]
  output logic      [sdiv_pkg::M_TUSER_W-1:0]    m_tuser,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [sdiv_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DISPATCH = 4'd1;
  localparam logic [3:0] ST_READ     = 4'd2;
  localparam logic [3:0] ST_FETCH_M  = 4'd3;
  localparam logic [3:0] ST_CHECK    = 4'd4;
  localparam logic [3:0] ST_DIV      = 4'd5;
  localparam logic [3:0] ST_WRITE_Q  = 4'd6;
  localparam logic [3:0] ST_PC_READ  = 4'd7;
  localparam logic [3:0] ST_PC_WRITE = 4'd8;
  localparam logic [3:0] ST_RESULT   = 4'd9;

  localparam int W  = sdiv_pkg::DATA_W;
  localparam int AW = sdiv_pkg::REG_ADDR_W;

  logic [3:0] state;
  logic [3:0] state_next;

  // configuration
  logic zero_divide_trap;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_divide_trap <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == sdiv_pkg::REG_ZERO_DIVIDE_TRAP) begin
      zero_divide_trap <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == sdiv_pkg::REG_ZERO_DIVIDE_TRAP) begin
      prdata[0] = zero_divide_trap;
    end
  end

  // latched command
  logic [1:0]    cmd;
  logic [AW-1:0] ri;
  logic [W-1:0]  wv;
  logic [W-1:0]  instr;
  logic          thumb;
  sdiv_pkg::decode_t dec;

  assign dec = sdiv_pkg::decode_instr(instr, thumb);

  // register file
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [W-1:0]          ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [W-1:0]          ram_rdata;
  logic [sdiv_pkg::REG_COUNT-1:0] written;
  logic                  rvalid;
  logic [W-1:0]          rdata;

  sdiv_ram #(
    .WIDTH (W),
    .DEPTH (sdiv_pkg::REG_COUNT)
  ) u_regfile (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rdata = rvalid ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rvalid  <= 1'b0;
    end else begin
      rvalid <= written[ram_raddr];
      if (ram_we) begin
        written[ram_waddr] <= 1'b1;
      end
    end
  end

  // divider
  logic         div_start;
  logic         div_done;
  logic [W-1:0] div_quo;
  logic [W-1:0] n_val;
  logic [W-1:0] n_mag;
  logic [W-1:0] m_mag;
  logic         q_neg;

  assign n_mag = (dec.is_signed && n_val[W-1]) ? (W'(0) - n_val) : n_val;
  assign m_mag = (dec.is_signed && rdata[W-1]) ? (W'(0) - rdata) : rdata;

  sdiv_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n_mag),
    .divisor  (m_mag),
    .done     (div_done),
    .quo      (div_quo)
  );

  // result being built
  logic [1:0]    res_status;
  logic [W-1:0]  res_read;
  logic [AW-1:0] res_dest;
  logic [W-1:0]  res_quo;

  logic accept_in;
  logic out_free;

  assign s_tready  = (state == ST_IDLE);
  assign accept_in = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = ri;
    ram_wdata  = wv;
    ram_raddr  = ri;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept_in) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (cmd)
          sdiv_pkg::CMD_WRITE: begin
            ram_we     = 1'b1;
            state_next = ST_RESULT;
          end
          sdiv_pkg::CMD_READ: begin
            state_next = ST_READ;
          end
          sdiv_pkg::CMD_EXEC: begin
            ram_raddr  = dec.rn;
            state_next = dec.is_div ? ST_FETCH_M : ST_RESULT;
          end
          default: begin
            state_next = ST_RESULT;
          end
        endcase
      end
      ST_READ: begin
        state_next = ST_RESULT;
      end
      ST_FETCH_M: begin
        ram_raddr  = dec.rm;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (rdata == '0) begin
          state_next = zero_divide_trap ? ST_RESULT : ST_WRITE_Q;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_WRITE_Q;
        end
      end
      ST_WRITE_Q: begin
        ram_we     = 1'b1;
        ram_waddr  = dec.rd;
        ram_wdata  = res_quo;
        state_next = ST_PC_READ;
      end
      ST_PC_READ: begin
        ram_raddr  = sdiv_pkg::PC_INDEX;
        state_next = ST_PC_WRITE;
      end
      ST_PC_WRITE: begin
        ram_we     = 1'b1;
        ram_waddr  = sdiv_pkg::PC_INDEX;
        ram_wdata  = rdata + sdiv_pkg::PC_STEP;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_RESULT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      cmd        <= s_tuser[1:0];
      thumb      <= s_tuser[2];
      ri         <= s_tdata[3:0];
      wv         <= s_tdata[35:4];
      instr      <= s_tdata[67:36];
      res_status <= sdiv_pkg::STATUS_DONE;
      res_read   <= '0;
      res_dest   <= '0;
      res_quo    <= '0;
    end
    unique case (state)
      ST_DISPATCH: begin
        if (cmd == sdiv_pkg::CMD_EXEC && !dec.is_div) begin
          res_status <= sdiv_pkg::STATUS_NOTDIV;
        end
      end
      ST_READ: begin
        res_read <= rdata;
      end
      ST_FETCH_M: begin
        n_val <= rdata;
      end
      ST_CHECK: begin
        q_neg <= dec.is_signed && (n_val[W-1] ^ rdata[W-1]);
        if (rdata == '0 && zero_divide_trap) begin
          res_status <= sdiv_pkg::STATUS_TRAP;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_quo <= q_neg ? (W'(0) - div_quo) : div_quo;
        end
      end
      ST_PC_WRITE: begin
        res_dest <= dec.rd;
      end
      default: begin
      end
    endcase
    if (state == ST_RESULT && out_free) begin
      m_tdata <= {4'b0, res_quo, res_dest, res_read};
      m_tuser <= res_status;
    end
  end

endmodule

`default_nettype wire
